/* rtl/core/gte_pkg.sv */
// gte_pkg: shared types and helpers for the graph traversal engine
// no dependencies; compiled first

package gte_pkg;

	localparam int unsigned FieldVertexW = 4;
	localparam int unsigned FieldRowW    = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_POP,
		ST_EXPAND
	} gte_state_t;

	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_RUN  = 1'b1
	} gte_req_t;

	typedef enum logic {
		MODE_BFS = 1'b0,
		MODE_DFS = 1'b1
	} gte_mode_t;

	// index of the lowest set bit, zero when none is set
	function automatic logic [FieldVertexW-1:0] lowest_set(input logic [FieldRowW-1:0] vec);
		logic [FieldVertexW-1:0] idx;
		idx = '0;
		for (int i = FieldRowW - 1; i >= 0; i--) begin
			if (vec[i]) idx = FieldVertexW'(i);
		end
		return idx;
	endfunction

endpackage

/* rtl/core/gte_ifs.sv */
// gte_ifs: valid/ready channel interfaces for the graph traversal engine
// request, result and mode-write channels; uses no package items

interface gte_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [3:0]  row_index;
	logic [15:0] row_bits;

	modport source(output valid, req_type, row_index, row_bits, input ready);
	modport sink(input valid, req_type, row_index, row_bits, output ready);
endinterface

interface gte_res_if;
	logic       valid;
	logic       ready;
	logic [3:0] vertex;
	logic       last_vertex;

	modport source(output valid, vertex, last_vertex, input ready);
	modport sink(input valid, vertex, last_vertex, output ready);
endinterface

interface gte_cfg_if;
	logic valid;
	logic ready;
	logic walk_mode;

	modport source(output valid, walk_mode, input ready);
	modport sink(input valid, walk_mode, output ready);
endinterface

/* rtl/core/graph_traversal_engine_core.sv */
// graph_traversal_engine_core: breadth-first / depth-first walk over an adjacency matrix
// depends on gte_pkg and the channel interfaces in gte_ifs.sv
//
//  channel | dir | words                               | ready
//  req     | in  | load row or start run               | only while sequencer idle
//  res     | out | one vertex per word, last flagged   | held in output register
//  cfg     | in  | walk_mode write                     | always
//
// a run steps through a push and a pop for each active vertex, a closing neighbor scan per
// popped vertex, an empty check per component and a final start check.
// reset clears control, mode, adjacency rows and marks; frontier entries are not reset.
// a stalled result holds the sequencer in its pop step; no word is dropped.

module graph_traversal_engine_core #(
	parameter int unsigned VERTEX_COUNT = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	gte_req_if.sink   req,
	gte_res_if.source res,
	gte_cfg_if.sink   cfg
);
	import gte_pkg::*;

	localparam int unsigned Active = (VERTEX_COUNT < 16) ? VERTEX_COUNT : 16;
	localparam int unsigned IW     = (Active > 1) ? $clog2(Active) : 1;
	localparam int unsigned PW     = $clog2(Active + 1);

	gte_state_t state_q, state_d;

	logic [Active-1:0] rows_q [Active];
	logic [IW-1:0]     frontier_q [Active];
	logic [Active-1:0] visited_q;
	logic [PW-1:0]     head_q, tail_q, cnt_q;
	logic [IW-1:0]     k_q;
	logic              mode_q;
	logic              out_valid_q;
	logic [IW-1:0]     out_vertex_q;
	logic              out_last_q;

	logic              empty, all_vis, out_free, run_acc, load_acc;
	logic [Active-1:0] cand;
	logic [IW-1:0]     start_v, cand_v, push_v, pop_v;
	logic [PW-1:0]     pop_ptr;
	logic              do_push, do_pop, in_ready;

	assign empty    = (head_q == tail_q);
	assign all_vis  = &visited_q;
	assign out_free = !out_valid_q || res.ready;
	assign cand     = rows_q[k_q] & ~visited_q;
	assign start_v  = IW'(lowest_set(FieldRowW'(~visited_q)));
	assign cand_v   = IW'(lowest_set(FieldRowW'(cand)));
	// stack pops from the top, queue from the head
	assign pop_ptr  = (mode_q == MODE_DFS) ? PW'(tail_q - PW'(1)) : head_q;
	assign pop_v    = frontier_q[pop_ptr[IW-1:0]];
	assign run_acc  = req.valid && in_ready && (req.req_type == REQ_RUN);
	assign load_acc = req.valid && in_ready && (req.req_type == REQ_LOAD);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (run_acc) state_d = ST_START;
			end
			ST_START: begin
				state_d = all_vis ? ST_IDLE : ST_POP;
			end
			ST_POP: begin
				if (empty) state_d = ST_START;
				else if (out_free) state_d = ST_EXPAND;
			end
			ST_EXPAND: begin
				if (cand == '0) state_d = ST_POP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		do_push  = 1'b0;
		do_pop   = 1'b0;
		push_v   = start_v;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_START:  do_push = !all_vis;
			ST_POP:    do_pop = !empty && out_free;
			ST_EXPAND: begin
				do_push = (cand != '0);
				push_v  = cand_v;
			end
			default: in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_BFS;
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < Active; i++) rows_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) mode_q <= cfg.walk_mode;
			if (load_acc && ({1'b0, req.row_index} < 5'(Active)))
				rows_q[req.row_index[IW-1:0]] <= req.row_bits[Active-1:0];
			if (run_acc) begin
				visited_q <= '0;
				head_q    <= '0;
				tail_q    <= '0;
				cnt_q     <= '0;
			end
			if (do_push) begin
				tail_q    <= PW'(tail_q + PW'(1));
				visited_q <= visited_q | (Active'(1) << push_v);
			end
			if (do_pop) begin
				if (mode_q == MODE_DFS) tail_q <= pop_ptr;
				else head_q <= PW'(head_q + PW'(1));
				cnt_q       <= PW'(cnt_q + PW'(1));
				k_q         <= pop_v;
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// frontier entries and result payload carry no reset
	always_ff @(posedge clk) begin
		if (do_push) frontier_q[tail_q[IW-1:0]] <= push_v;
		if (do_pop) begin
			out_vertex_q <= pop_v;
			out_last_q   <= (cnt_q == PW'(Active - 1));
		end
	end

	assign req.ready       = in_ready;
	assign cfg.ready       = 1'b1;
	assign res.valid       = out_valid_q;
	assign res.vertex      = FieldVertexW'(out_vertex_q);
	assign res.last_vertex = out_last_q;

endmodule

/* bench/traversal_checker.sv */
`timescale 1ns / 100ps
// traversal_checker: watches the request, mode and result channels, predicts the
// vertex order of every accepted walk and compares each result word with it
// depends on gte_pkg and the channel interfaces in gte_ifs.sv

module traversal_checker #(
	parameter int unsigned VERTICES = 16
) (
	input  logic clk,
	input  logic arst_n,
	gte_req_if   req,
	gte_res_if   res,
	gte_cfg_if   cfg,
	output int   mismatch_count,
	output int   words_outstanding,
	output int   load_count,
	output int   bfs_runs,
	output int   dfs_runs,
	output int   words_checked
);
	import gte_pkg::*;

	localparam int unsigned ACTIVE = (VERTICES < 16) ? VERTICES : 16;
	localparam logic [15:0] ACTIVE_MASK = 16'((32'd1 << ACTIVE) - 1);

	typedef struct packed {
		logic [3:0] vertex;
		logic       last_vertex;
	} visit_word_t;

	logic [15:0] adjacency [16];
	gte_mode_t   walk_mode;
	visit_word_t visit_order [$];

	// marks are set when a vertex enters the frontier, not when it is emitted
	function automatic void predict_walk();
		logic [15:0] marks;
		logic [3:0]  frontier [16];
		logic [3:0]  k;
		int          fill;
		int          head;
		int          emitted;
		marks = '0;
		fill = 0;
		head = 0;
		emitted = 0;
		for (int s = 0; s < ACTIVE; s++) begin
			if (!marks[s]) begin
				frontier[fill] = 4'(s);
				fill++;
				marks[s] = 1'b1;
				while (fill != head) begin
					if (walk_mode == MODE_DFS) begin
						fill--;
						k = frontier[fill];
					end else begin
						k = frontier[head];
						head++;
					end
					visit_order.push_back('{vertex: k, last_vertex: (emitted == ACTIVE - 1)});
					emitted++;
					for (int j = 0; j < ACTIVE; j++) begin
						if (adjacency[k][j] && !marks[j]) begin
							frontier[fill] = 4'(j);
							fill++;
							marks[j] = 1'b1;
						end
					end
				end
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		visit_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) adjacency[i] = '0;
			walk_mode = MODE_BFS;
			visit_order.delete();
			mismatch_count <= 0;
			words_outstanding <= 0;
			load_count <= 0;
			bfs_runs <= 0;
			dfs_runs <= 0;
			words_checked <= 0;
		end else begin
			if (cfg.valid && cfg.ready) walk_mode = gte_mode_t'(cfg.walk_mode);

			if (req.valid && req.ready) begin
				if (req.req_type == REQ_LOAD) begin
					load_count <= load_count + 1;
					if (req.row_index < ACTIVE) adjacency[req.row_index] = req.row_bits & ACTIVE_MASK;
				end else begin
					if (walk_mode == MODE_DFS) dfs_runs <= dfs_runs + 1;
					else bfs_runs <= bfs_runs + 1;
					predict_walk();
				end
			end

			if (res.valid && res.ready) begin
				words_checked <= words_checked + 1;
				if (visit_order.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected word: vertex %0d last %0b", res.vertex, res.last_vertex);
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = visit_order.pop_front();
					if (res.vertex !== want.vertex || res.last_vertex !== want.last_vertex) begin
						if (mismatch_count < 10)
							$display("word %0d: expected vertex %0d last %0b, got vertex %0d last %0b",
								words_checked, want.vertex, want.last_vertex,
								res.vertex, res.last_vertex);
						mismatch_count <= mismatch_count + 1;
					end
				end
			end

			words_outstanding <= visit_order.size();
		end
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// testbench: drives row loads, walks and mode writes into the traversal engine
// under several idle/stall mixes; depends on gte_pkg, gte_ifs.sv and traversal_checker

module testbench;
	import gte_pkg::*;

	localparam int CYCLE_LIMIT    = 300000;
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int PHASE_ITEMS    = 29;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int holdoff_arm = 0;
	int holdoff_seen = 0;
	int holdoff_left = 0;
	int cycle_count = 0;

	int mismatch_count;
	int words_outstanding;
	int load_count;
	int bfs_runs;
	int dfs_runs;
	int words_checked;

	gte_req_if req_ch();
	gte_res_if res_ch();
	gte_cfg_if cfg_ch();

	graph_traversal_engine_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	traversal_checker scoreboard (
		.clk               (clk),
		.arst_n            (arst_n),
		.req               (req_ch),
		.res               (res_ch),
		.cfg               (cfg_ch),
		.mismatch_count    (mismatch_count),
		.words_outstanding (words_outstanding),
		.load_count        (load_count),
		.bfs_runs          (bfs_runs),
		.dfs_runs          (dfs_runs),
		.words_checked     (words_checked)
	);

	always #5 clk = ~clk;

	// result ready: random stalls, or a long hold-off counted here once armed
	always @(posedge clk) begin
		if (holdoff_arm != holdoff_seen) begin
			holdoff_seen <= holdoff_arm;
			holdoff_left <= HOLDOFF_CYCLES;
			res_ch.ready <= 1'b0;
		end else if (holdoff_left > 0) begin
			holdoff_left <= holdoff_left - 1;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// valid stays high across back-to-back words, it only drops while idling
	task automatic send_word(input gte_req_t kind, input logic [3:0] idx, input logic [15:0] bits);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.row_index <= idx;
		req_ch.row_bits <= bits;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	task automatic load_row(input logic [3:0] idx, input logic [15:0] bits);
		send_word(REQ_LOAD, idx, bits);
	endtask

	// row fields are ignored by a walk, so they carry noise
	task automatic start_walk();
		send_word(REQ_RUN, 4'($urandom_range(15, 0)), 16'($urandom));
	endtask

	// release valid and wait out the current edge so a walk accepted on it shows up in the count
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input gte_mode_t mode);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.walk_mode <= mode;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// mostly sparse rows so graphs split into several components
	function automatic logic [15:0] random_row();
		case ($urandom_range(5, 0))
			0: return '0;
			1: return '1;
			2: return 16'(32'd1 << $urandom_range(15, 0));
			5: return 16'($urandom);
			default: return 16'($urandom & $urandom & $urandom);
		endcase
	endfunction

	task automatic random_traffic(input int count);
		repeat (count) begin
			if ($urandom_range(3, 0) == 0) start_walk();
			else load_row(4'($urandom_range(15, 0)), random_row());
		end
	endtask

	initial begin
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_LOAD;
		req_ch.row_index = '0;
		req_ch.row_bits = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.walk_mode = MODE_BFS;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty graph walks in plain index order
		write_mode(MODE_BFS);
		start_walk();
		// full rows at both index extremes, self loops included
		load_row(4'd0, 16'hFFFF);
		load_row(4'd15, 16'hFFFF);
		start_walk();
		write_mode(MODE_DFS);
		start_walk();
		// chains, a lone self loop and several components
		load_row(4'd0, 16'h0000);
		load_row(4'd15, 16'h0000);
		load_row(4'd3, 16'h0080);
		load_row(4'd7, 16'h0004);
		load_row(4'd5, 16'h0020);
		load_row(4'd9, 16'h8001);
		load_row(4'd2, 16'h0A00);
		start_walk();
		write_mode(MODE_BFS);
		start_walk();

		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 78;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 78;
				end
				default: begin
					send_idle_pct = 9;
					stall_pct = 9;
				end
			endcase
			write_mode((phase % 2) ? MODE_DFS : MODE_BFS);
			if (phase == 0) begin
				// results back up behind a long hold-off while loads keep coming
				holdoff_arm <= holdoff_arm + 1;
				start_walk();
			end
			random_traffic(PHASE_ITEMS);
		end

		drain();
		$display("covered %0d row loads and %0d walks (%0d breadth-first, %0d depth-first)",
			load_count, bfs_runs + dfs_runs, bfs_runs, dfs_runs);
		$display("%0d vertex words checked across idle, stall, mixed and hold-off traffic",
			words_checked);
		if (mismatch_count == 0 && words_outstanding == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/gte_pkg.sv
rtl/core/gte_ifs.sv
rtl/core/graph_traversal_engine_core.sv
bench/traversal_checker.sv
bench/testbench.sv
